// File: rtl/wamm_pkg.sv
// wamm_pkg: shared constants and types for the window average/min/max block.
// No dependencies; imported by every module under rtl/.
package wamm_pkg;

  localparam int NUM_AXES = 3;
  localparam int AXIS_X   = 0;
  localparam int AXIS_Y   = 1;
  localparam int AXIS_Z   = 2;

  // configuration port
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;
  localparam int CFG_LEN_W   = 7;
  localparam logic [CFG_LEN_W-1:0] CFG_LEN_RESET = 7'd8;
  localparam logic REG_WINDOW_LENGTH = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LOAD,
    ST_DIV
  } state_t;

endpackage

// File: rtl/wamm_cell.sv
// wamm_cell: one window slot. Holds a three-axis sample that shifts to the
// next slot on each transfer, and, when inside the window, folds it into the passing sum/max/min.
// Depends on wamm_pkg.
module wamm_cell import wamm_pkg::*; #(
  parameter int CELL_IDX    = 0,
  parameter int LEN_W       = 7,
  parameter int SAMPLE_BITS = 16,
  parameter int SUM_W       = 22
) (
  input  logic                                   clk,
  input  logic                                   shift,
  input  logic [LEN_W-1:0]                       len,
  input  logic [NUM_AXES-1:0][SAMPLE_BITS-1:0]   smp_in,
  output logic [NUM_AXES-1:0][SAMPLE_BITS-1:0]   smp,
  input  logic [NUM_AXES-1:0][SUM_W-1:0]         sum_in,
  input  logic [NUM_AXES-1:0][SAMPLE_BITS-1:0]   hi_in,
  input  logic [NUM_AXES-1:0][SAMPLE_BITS-1:0]   lo_in,
  output logic [NUM_AXES-1:0][SUM_W-1:0]         sum_out,
  output logic [NUM_AXES-1:0][SAMPLE_BITS-1:0]   hi_out,
  output logic [NUM_AXES-1:0][SAMPLE_BITS-1:0]   lo_out
);

  localparam logic [LEN_W-1:0] IDX_L = LEN_W'(CELL_IDX);

  logic in_win;
  assign in_win = (len > IDX_L);

  always_ff @(posedge clk) begin
    if (shift) begin
      smp <= smp_in;
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < NUM_AXES; a++) begin
      if (in_win) begin
        sum_out[a] <= sum_in[a]
                      + {{(SUM_W-SAMPLE_BITS){smp[a][SAMPLE_BITS-1]}}, smp[a]};
        hi_out[a]  <= ($signed(smp[a]) > $signed(hi_in[a])) ? smp[a] : hi_in[a];
        lo_out[a]  <= ($signed(smp[a]) < $signed(lo_in[a])) ? smp[a] : lo_in[a];
      end else begin
        sum_out[a] <= sum_in[a];
        hi_out[a]  <= hi_in[a];
        lo_out[a]  <= lo_in[a];
      end
    end
  end

endmodule

// File: rtl/wamm_div.sv
// wamm_div: signed-by-unsigned divider, one quotient bit per cycle,
// truncating toward zero. Depends on wamm_pkg.
module wamm_div import wamm_pkg::*; #(
  parameter int SUM_W       = 22,
  parameter int LEN_W       = 7,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [SUM_W-1:0]              dividend,
  input  logic [LEN_W-1:0]              divisor,
  output logic                          busy,
  output logic [SAMPLE_BITS-1:0]        quotient
);

  localparam int CNT_W = $clog2(SUM_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SUM_W - 1);

  logic             neg;
  logic [SUM_W-1:0] mag;   // dividend bits shift out, quotient bits shift in
  logic [LEN_W:0]   rem;
  logic [CNT_W-1:0] cnt;
  logic [LEN_W:0]   rem_sh;
  logic             ge;
  logic [SUM_W-1:0] q_full;

  assign rem_sh = {rem[LEN_W-1:0], mag[SUM_W-1]};
  assign ge     = (rem_sh >= {1'b0, divisor});
  assign q_full = neg ? (~mag + 1'b1) : mag;
  assign quotient = q_full[SAMPLE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == CNT_LAST) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[SUM_W-1];
      mag <= dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
      rem <= '0;
      cnt <= '0;
    end else if (busy) begin
      rem <= ge ? (rem_sh - {1'b0, divisor}) : rem_sh;
      mag <= {mag[SUM_W-2:0], ge};
      cnt <= cnt + 1'b1;
    end
  end

endmodule

// File: rtl/window_average_min_max_3axis.sv
// window_average_min_max_3axis: top level. Chain of window cells, three
// dividers for the means, APB-style register port. Depends on wamm_pkg,
// wamm_cell, wamm_div.
//
// Usage
//   Input channel: sample_x/y/z with in_valid/in_stall; one transfer per
//   sample. Output channel: mean_x/y/z, max/min per axis with
//   out_valid/out_stall. window_length (register 0, byte address 0) sets how
//   many of the newest samples are covered; 0 acts as 1, values above
//   MAX_WINDOW act as MAX_WINDOW. Write it only while the block is idle.
//   Samples shift into a chain of MAX_WINDOW cells; no result is given until
//   window_length samples are stored, after that one result per sample.
//   A sample that gives no result leaves the block idle. Otherwise the
//   partial sum/max/min walks the whole chain, one cell per cycle, in the
//   scan state; a load state starts the dividers, which take one quotient
//   bit per cycle over the SUM_W-bit sum, truncating toward zero.
//   One sample is worked on at a time; in_stall is high from transfer until
//   the result sits in the output register. A result held by out_stall does
//   not block the next sample; a second result waits in the dividers.
//   Reset clears the fill count, the output valid and sets window_length 8.
module window_average_min_max_3axis import wamm_pkg::*; #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_W-1:0]             paddr,
  input  logic [DATA_W-1:0]             pwdata,
  output logic [DATA_W-1:0]             prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample_x,
  input  logic signed [SAMPLE_BITS-1:0] sample_y,
  input  logic signed [SAMPLE_BITS-1:0] sample_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] mean_x,
  output logic signed [SAMPLE_BITS-1:0] mean_y,
  output logic signed [SAMPLE_BITS-1:0] mean_z,
  output logic signed [SAMPLE_BITS-1:0] max_x,
  output logic signed [SAMPLE_BITS-1:0] min_x,
  output logic signed [SAMPLE_BITS-1:0] max_y,
  output logic signed [SAMPLE_BITS-1:0] min_y,
  output logic signed [SAMPLE_BITS-1:0] max_z,
  output logic signed [SAMPLE_BITS-1:0] min_z
);

  localparam int LEN_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int CNT_W = $clog2(MAX_WINDOW);
  localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(MAX_WINDOW);
  localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(MAX_WINDOW - 1);

  // ---------------- register port ----------------
  logic [CFG_LEN_W-1:0] window_length;
  logic                 cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= CFG_LEN_RESET;
    end else if (cfg_wr && paddr[ADDR_W-1] == REG_WINDOW_LENGTH) begin
      window_length <= pwdata[CFG_LEN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[ADDR_W-1] == REG_WINDOW_LENGTH) begin
      prdata = DATA_W'(window_length);
    end
  end

  logic [LEN_W-1:0] len_eff;
  always_comb begin
    if (window_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (int'(window_length) > MAX_WINDOW) begin
      len_eff = MAX_LEN;
    end else begin
      len_eff = LEN_W'(window_length);
    end
  end

  // ---------------- control ----------------
  state_t           state, state_next;
  logic [CNT_W-1:0] scan_cnt;
  logic [LEN_W-1:0] fill_count, fill_next;
  logic             in_xfer;
  logic             div_start;
  logic             out_load;
  logic [NUM_AXES-1:0] div_busy;

  assign in_stall  = (state != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign fill_next = (fill_count == MAX_LEN) ? fill_count : fill_count + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_xfer && fill_next >= len_eff) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_cnt == SCAN_END) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_busy == '0 && (!out_valid || !out_stall)) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (in_xfer) begin
      fill_count <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt <= '0;
    end else if (state == ST_SCAN) begin
      scan_cnt <= scan_cnt + 1'b1;
    end else begin
      scan_cnt <= '0;
    end
  end

  // ---------------- cell chain ----------------
  // cell 0 holds the newest sample; the fold runs from the newest outward
  logic [MAX_WINDOW-1:0][NUM_AXES-1:0][SAMPLE_BITS-1:0] smp_chain;
  logic [NUM_AXES-1:0][SAMPLE_BITS-1:0]                 smp_new;
  logic [MAX_WINDOW:0][NUM_AXES-1:0][SUM_W-1:0]         sum_chain;
  logic [MAX_WINDOW:0][NUM_AXES-1:0][SAMPLE_BITS-1:0]   hi_chain;
  logic [MAX_WINDOW:0][NUM_AXES-1:0][SAMPLE_BITS-1:0]   lo_chain;

  assign smp_new[AXIS_X] = sample_x;
  assign smp_new[AXIS_Y] = sample_y;
  assign smp_new[AXIS_Z] = sample_z;

  assign sum_chain[0] = '0;
  assign hi_chain[0]  = smp_chain[0];
  assign lo_chain[0]  = smp_chain[0];

  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    logic [NUM_AXES-1:0][SAMPLE_BITS-1:0] cell_in;
    if (k == 0) begin : g_head
      assign cell_in = smp_new;
    end else begin : g_body
      assign cell_in = smp_chain[k-1];
    end
    wamm_cell #(
      .CELL_IDX    (k),
      .LEN_W       (LEN_W),
      .SAMPLE_BITS (SAMPLE_BITS),
      .SUM_W       (SUM_W)
    ) u_cell (
      .clk     (clk),
      .shift   (in_xfer),
      .len     (len_eff),
      .smp_in  (cell_in),
      .smp     (smp_chain[k]),
      .sum_in  (sum_chain[k]),
      .hi_in   (hi_chain[k]),
      .lo_in   (lo_chain[k]),
      .sum_out (sum_chain[k+1]),
      .hi_out  (hi_chain[k+1]),
      .lo_out  (lo_chain[k+1])
    );
  end

  // ---------------- means ----------------
  logic [NUM_AXES-1:0][SAMPLE_BITS-1:0] quot;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_div
    wamm_div #(
      .SUM_W       (SUM_W),
      .LEN_W       (LEN_W),
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_div (
      .clk      (clk),
      .rst      (rst),
      .start    (div_start),
      .dividend (sum_chain[MAX_WINDOW][a]),
      .divisor  (len_eff),
      .busy     (div_busy[a]),
      .quotient (quot[a])
    );
  end

  // ---------------- output register ----------------
  logic [NUM_AXES-1:0][SAMPLE_BITS-1:0] mean_q, hi_q, lo_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      mean_q <= quot;
      hi_q   <= hi_chain[MAX_WINDOW];
      lo_q   <= lo_chain[MAX_WINDOW];
    end
  end

  assign mean_x = mean_q[AXIS_X];
  assign mean_y = mean_q[AXIS_Y];
  assign mean_z = mean_q[AXIS_Z];
  assign max_x  = hi_q[AXIS_X];
  assign min_x  = lo_q[AXIS_X];
  assign max_y  = hi_q[AXIS_Y];
  assign min_y  = lo_q[AXIS_Y];
  assign max_z  = hi_q[AXIS_Z];
  assign min_z  = lo_q[AXIS_Z];

  // ---------------- assertions ----------------
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= MAX_LEN)
    else $error("fill count past window depth");

  a_div_in_div: assert property (@(posedge clk) disable iff (rst)
    (div_busy != '0) |-> (state == ST_DIV))
    else $error("divider running outside divide phase");

  a_scan_start: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && fill_next >= len_eff) |=> (state == ST_SCAN))
    else $error("full window transfer did not start a scan");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !out_load)
    else $error("result overwritten while held");

endmodule

// File: tb/tb_window_average_min_max_3axis.sv
// Testbench for window_average_min_max_3axis: directed and random samples, several window
// lengths through the register port, and a per-field check of every result.
// Depends on wamm_pkg and the RTL under rtl/.
module tb_window_average_min_max_3axis;
  import wamm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_WINDOW     = 64;
  localparam int SAMPLE_BITS    = 16;
  localparam int SETTLE_CYCLES  = 100;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_PRINTED    = 40;
  localparam int REG_UNUSED     = 1;

  typedef logic [NUM_AXES-1:0][SAMPLE_BITS-1:0] triple_t;
  typedef struct packed {
    triple_t mean;
    triple_t hi;
    triple_t lo;
  } stats_t;

  logic                          clk;
  logic                          rst;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [ADDR_W-1:0]             paddr;
  logic [DATA_W-1:0]             pwdata;
  logic [DATA_W-1:0]             prdata;
  logic                          pready;
  logic                          in_valid;
  logic                          in_stall;
  logic signed [SAMPLE_BITS-1:0] sample_x;
  logic signed [SAMPLE_BITS-1:0] sample_y;
  logic signed [SAMPLE_BITS-1:0] sample_z;
  logic                          out_valid;
  logic                          out_stall;
  logic signed [SAMPLE_BITS-1:0] mean_x;
  logic signed [SAMPLE_BITS-1:0] mean_y;
  logic signed [SAMPLE_BITS-1:0] mean_z;
  logic signed [SAMPLE_BITS-1:0] max_x;
  logic signed [SAMPLE_BITS-1:0] min_x;
  logic signed [SAMPLE_BITS-1:0] max_y;
  logic signed [SAMPLE_BITS-1:0] min_y;
  logic signed [SAMPLE_BITS-1:0] max_z;
  logic signed [SAMPLE_BITS-1:0] min_z;

  window_average_min_max_3axis #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sample_x (sample_x),
    .sample_y (sample_y),
    .sample_z (sample_z),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .mean_x   (mean_x),
    .mean_y   (mean_y),
    .mean_z   (mean_z),
    .max_x    (max_x),
    .min_x    (min_x),
    .max_y    (max_y),
    .min_y    (min_y),
    .max_z    (max_z),
    .min_z    (min_z)
  );

  // predictor state
  logic signed [SAMPLE_BITS-1:0] win [NUM_AXES][MAX_WINDOW];
  int unsigned                   wr_ptr;
  int unsigned                   fill_cnt;
  logic [CFG_LEN_W-1:0]          cfg_len;

  stats_t expected_stats[$];
  int     errors;
  int     idle_cycles;
  int     hold_cycles;
  bit     tx_idle_en;
  bit     rx_idle_en;
  string  axis_name[NUM_AXES] = '{"x", "y", "z"};

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  task automatic report_mismatch(input string msg);
    if (errors < MAX_PRINTED) $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // Pushes the sample into the window; returns 1 with the stats when a result is due.
  function automatic bit window_stats(input triple_t smp, output stats_t res);
    int unsigned len;
    longint      acc;
    logic signed [SAMPLE_BITS-1:0] v;
    logic signed [SAMPLE_BITS-1:0] hi;
    logic signed [SAMPLE_BITS-1:0] lo;
    len = (cfg_len == 0) ? 1 : (cfg_len > MAX_WINDOW) ? MAX_WINDOW : cfg_len;
    for (int a = 0; a < NUM_AXES; a++) win[a][wr_ptr] = smp[a];
    wr_ptr = (wr_ptr + 1) % MAX_WINDOW;
    if (fill_cnt < MAX_WINDOW) fill_cnt++;
    res = '0;
    if (fill_cnt < len) return 1'b0;
    for (int a = 0; a < NUM_AXES; a++) begin
      acc = 0;
      hi  = win[a][(wr_ptr + MAX_WINDOW - 1) % MAX_WINDOW];
      lo  = hi;
      for (int k = 0; k < len; k++) begin
        v   = win[a][(wr_ptr + 2 * MAX_WINDOW - 1 - k) % MAX_WINDOW];
        acc += v;
        if (v > hi) hi = v;
        if (v < lo) lo = v;
      end
      res.mean[a] = SAMPLE_BITS'(acc / longint'(len));
      res.hi[a]   = hi;
      res.lo[a]   = lo;
    end
    return 1'b1;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] rand_value();
    logic [SAMPLE_BITS-1:0] v;
    case ($urandom_range(9))
      0:       v = 16'h8000;
      1:       v = 16'h7fff;
      2, 3:    v = SAMPLE_BITS'(int'($urandom_range(0, 16)) - 8);
      default: v = SAMPLE_BITS'($urandom);
    endcase
    return v;
  endfunction

  // One transfer on the input channel; the predictor runs at the accepting edge.
  task automatic send_sample(input triple_t smp);
    stats_t res;
    if (tx_idle_en && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_x <= smp[AXIS_X];
    sample_y <= smp[AXIS_Y];
    sample_z <= smp[AXIS_Z];
    do @(posedge clk); while (in_stall);
    if (window_stats(smp, res)) expected_stats.push_back(res);
  endtask

  task automatic send_random(input int count);
    triple_t smp;
    repeat (count) begin
      for (int a = 0; a < NUM_AXES; a++) smp[a] = rand_value();
      send_sample(smp);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_stats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input bit wr, input int idx, input logic [DATA_W-1:0] data,
                            output logic [DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_W'(idx * 4);
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (wr && idx == REG_WINDOW_LENGTH) cfg_len = data[CFG_LEN_W-1:0];
  endtask

  // Block must be idle; writes the register (or an unused slot) and reads the length back.
  task automatic write_length(input int idx, input logic [DATA_W-1:0] data);
    logic [DATA_W-1:0] rdata;
    wait_drained();
    apb_access(1'b1, idx, data, rdata);
    apb_access(1'b0, REG_WINDOW_LENGTH, '0, rdata);
    if (rdata !== DATA_W'(cfg_len))
      report_mismatch($sformatf("window_length read %0d expected %0d", rdata, cfg_len));
  endtask

  task automatic test_directed_extremes();
    logic [DATA_W-1:0] rdata;
    apb_access(1'b0, REG_WINDOW_LENGTH, '0, rdata);
    if (rdata !== DATA_W'(CFG_LEN_RESET))
      report_mismatch($sformatf("window_length after reset read %0d", rdata));
    // half full scale low, half high: mean rounds toward zero
    repeat (4) send_sample({3{16'h8000}});
    repeat (4) send_sample({3{16'h7fff}});
    send_sample({16'hffff, 16'h0000, 16'h0001});
    send_sample({16'h5555, 16'haaaa, 16'h5555});
    send_sample({16'haaaa, 16'h5555, 16'h8000});
    send_sample({16'h0000, 16'h7fff, 16'hffff});
  endtask

  task automatic test_length_corners();
    write_length(REG_WINDOW_LENGTH, 1);
    send_sample({16'h8000, 16'h7fff, 16'hfff9});
    send_sample({16'h0003, 16'hfffd, 16'h8001});
    write_length(REG_WINDOW_LENGTH, 0);
    send_sample({16'h7fff, 16'h8000, 16'h0000});
    send_sample({16'hffff, 16'h0001, 16'h7ffe});
    // unused register slot: length must stay 3
    write_length(REG_WINDOW_LENGTH, 3);
    write_length(REG_UNUSED, 64);
    send_sample({16'hfffe, 16'hfffb, 16'h0007});
    send_sample({16'h0005, 16'h8000, 16'h7fff});
  endtask

  task automatic test_random_lengths();
    int lengths[10] = '{127, 2, 64, 17, 65, 1, 33, 0, 5, 8};
    foreach (lengths[i]) begin
      // upper bits of the write data are don't-care
      write_length(REG_WINDOW_LENGTH, {$urandom} << CFG_LEN_W | lengths[i]);
      send_random(80);
    end
  endtask

  task automatic test_no_idle();
    write_length(REG_WINDOW_LENGTH, 64);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_random(60);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  task automatic test_output_hold();
    write_length(REG_WINDOW_LENGTH, 2);
    hold_cycles = 400;
    send_random(12);
  endtask

  task automatic test_sender_pause();
    write_length(REG_WINDOW_LENGTH, 5);
    send_random(20);
    wait_drained();
    send_random(20);
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else begin
      out_stall <= rx_idle_en && ($urandom_range(99) < 20);
    end
  end

  always @(posedge clk) begin
    stats_t got;
    stats_t exp_res;
    if (!rst && out_valid && !out_stall) begin
      got.mean = {mean_z, mean_y, mean_x};
      got.hi   = {max_z, max_y, max_x};
      got.lo   = {min_z, min_y, min_x};
      if (expected_stats.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        exp_res = expected_stats.pop_front();
        for (int a = 0; a < NUM_AXES; a++) begin
          if (got.mean[a] !== exp_res.mean[a])
            report_mismatch($sformatf("mean_%s got %0d expected %0d", axis_name[a],
                            $signed(got.mean[a]), $signed(exp_res.mean[a])));
          if (got.hi[a] !== exp_res.hi[a])
            report_mismatch($sformatf("max_%s got %0d expected %0d", axis_name[a],
                            $signed(got.hi[a]), $signed(exp_res.hi[a])));
          if (got.lo[a] !== exp_res.lo[a])
            report_mismatch($sformatf("min_%s got %0d expected %0d", axis_name[a],
                            $signed(got.lo[a]), $signed(exp_res.lo[a])));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_window_average_min_max_3axis failed");
      $finish;
    end
  end

  initial begin
    rst         <= 1'b1;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    in_valid    <= 1'b0;
    sample_x    <= '0;
    sample_y    <= '0;
    sample_z    <= '0;
    out_stall   <= 1'b0;
    errors      = 0;
    idle_cycles = 0;
    hold_cycles = 0;
    tx_idle_en  = 1'b1;
    rx_idle_en  = 1'b1;
    wr_ptr      = 0;
    fill_cnt    = 0;
    cfg_len     = CFG_LEN_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_extremes();
    test_length_corners();
    test_random_lengths();
    test_no_idle();
    test_output_hold();
    test_sender_pause();

    wait_drained();
    if (errors == 0) begin
      $display("tb_window_average_min_max_3axis passed");
    end else begin
      $display("tb_window_average_min_max_3axis failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/wamm_pkg.sv
rtl/wamm_cell.sv
rtl/wamm_div.sv
rtl/window_average_min_max_3axis.sv
tb/tb_window_average_min_max_3axis.sv
